// ===== sv/wepp_pkg.sv =====
// ----------------------------------------------------------------------------
// wepp_pkg
// Shared types and constants for the wall edge perspective projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package wepp_pkg;

  // datapath widths
  localparam int NUM_W      = 64;  // numerator magnitude
  localparam int DEN_W      = 48;  // positive denominator
  localparam int QUO_W      = 16;  // quotient bits before saturation
  localparam int DIV_STAGES = QUO_W;
  localparam int N_LANES    = 6;
  localparam int OUT_W      = 16;

  // projection constants
  localparam int HEIGHT_DIV = 60;
  localparam int DEPTH_FRAC = 22;

  // divider lane assignment
  localparam int LANE_X1   = 0;
  localparam int LANE_TOP1 = 1;
  localparam int LANE_BOT1 = 2;
  localparam int LANE_X2   = 3;
  localparam int LANE_TOP2 = 4;
  localparam int LANE_BOT2 = 5;

  // segment order within one edge
  typedef enum logic [1:0] {
    SEG_TOP    = 2'd0,
    SEG_BOTTOM = 2'd1,
    SEG_LEFT   = 2'd2,
    SEG_RIGHT  = 2'd3
  } seg_kind_e;

  // configuration register index
  typedef enum logic [1:0] {
    REG_CAMERA_X  = 2'd0,
    REG_CAMERA_Y  = 2'd1,
    REG_COS_ANGLE = 2'd2,
    REG_SIN_ANGLE = 2'd3
  } reg_idx_e;

  // one division in flight
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef div_lane_t [N_LANES-1:0] lanes_t;

endpackage

`default_nettype wire

// ===== sv/wall_edge_perspective_project.sv =====
// ----------------------------------------------------------------------------
// wall_edge_perspective_project
// Rotates both vertices of a wall edge into camera space, divides by depth
// and emits the four screen segments of the edge (top, bottom, left, right).
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o | two vertices, height
//   out     | output    | out_valid_o/out_stall_i | one segment per transfer
//   cfg     | input     | APB psel/penable/pready | camera position, cos, sin
//
// An edge passes 5 front stages, 16 divider stages (one quotient bit each),
// a saturation stage and a holding register, which sends four segments,
// one per cycle when the output is not stalled; it takes a new edge when
// empty or as its last segment is sent. Reset clears all valid bits and
// loads the camera registers. An output stall freezes the pipeline once a
// finished edge waits for the busy holding register; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_edge_perspective_project
  import wepp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 600
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // edge input
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [23:0] first_x_i,
  input  wire logic signed [23:0] first_y_i,
  input  wire logic signed [23:0] second_x_i,
  input  wire logic signed [23:0] second_y_i,
  input  wire logic [15:0]        wall_height_i,
  // segment output
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      start_x_o,
  output logic signed [15:0]      start_y_o,
  output logic signed [15:0]      end_x_o,
  output logic signed [15:0]      end_y_o,
  output logic [1:0]              segment_kind_o,
  output logic                    behind_camera_o,
  output logic                    last_segment_o
);

  localparam logic signed [NUM_W-1:0] CW     = NUM_W'(SCREEN_WIDTH / 2);
  localparam logic signed [NUM_W-1:0] K60CH  = NUM_W'(HEIGHT_DIV * (SCREEN_HEIGHT / 2));
  localparam logic signed [NUM_W-1:0] WH     = NUM_W'(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam logic signed [NUM_W-1:0] K60    = NUM_W'(HEIGHT_DIV);

  // configuration registers
  logic signed [23:0] cam_x_q, cam_y_q;
  logic signed [15:0] cos_q, sin_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cos_q   <= 16'sd16384;
      sin_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAMERA_X:  cam_x_q <= pwdata[23:0];
        REG_CAMERA_Y:  cam_y_q <= pwdata[23:0];
        REG_COS_ANGLE: cos_q   <= pwdata[15:0];
        REG_SIN_ANGLE: sin_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back, sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_CAMERA_X:  prdata = 32'(cam_x_q);
      REG_CAMERA_Y:  prdata = 32'(cam_y_q);
      REG_COS_ANGLE: prdata = 32'(cos_q);
      REG_SIN_ANGLE: prdata = 32'(sin_q);
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, fin_valid_q;
  logic div_valid;
  logic hold_valid_q, load_ok, hold_load, out_fire;
  seg_kind_e seg_q;

  assign out_fire  = hold_valid_q && !out_stall_i;
  assign load_ok   = !hold_valid_q || (out_fire && (seg_q == SEG_RIGHT));
  assign adv       = !fin_valid_q || load_ok;
  assign hold_load = fin_valid_q && load_ok;
  assign in_stall_o = !adv;

  // stage 1: offsets from camera
  logic signed [24:0] dx_q [2];
  logic signed [24:0] dy_q [2];
  logic [15:0]        h1_q, h2_q, h3_q;

  // stage 2: rotation products
  logic signed [40:0] pxc_q [2];
  logic signed [40:0] pys_q [2];
  logic signed [40:0] pxs_q [2];
  logic signed [40:0] pyc_q [2];

  // stage 3: depth and lateral offset
  logic signed [41:0] z_q   [2];
  logic signed [41:0] lat_q [2];

  // stage 4: numerators and denominators
  logic signed [NUM_W-1:0] num_q [N_LANES];
  logic [DEN_W-1:0]        den_q [N_LANES];
  logic                    beh4_q;

  // stage 5: magnitudes and overflow
  lanes_t lanes5_q;
  logic   beh5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[0] <= 25'(first_x_i) - 25'(cam_x_q);
      dy_q[0] <= 25'(first_y_i) - 25'(cam_y_q);
      dx_q[1] <= 25'(second_x_i) - 25'(cam_x_q);
      dy_q[1] <= 25'(second_y_i) - 25'(cam_y_q);
      h1_q    <= wall_height_i;
      h2_q    <= h1_q;
      h3_q    <= h2_q;
      for (int v = 0; v < 2; v++) begin
        pxc_q[v] <= dx_q[v] * cos_q;
        pys_q[v] <= dy_q[v] * sin_q;
        pxs_q[v] <= dx_q[v] * sin_q;
        pyc_q[v] <= dy_q[v] * cos_q;
        z_q[v]   <= 42'(pxc_q[v]) + 42'(pys_q[v]);
        lat_q[v] <= 42'(pxs_q[v]) - 42'(pyc_q[v]);
      end
    end
  end

  // stage 4 numerators: x uses cw*(z-lat)/z, y uses (60*ch*z + off*2^22)/(60*z)
  always_ff @(posedge clk_i) begin
    logic signed [NUM_W-1:0] z64;
    logic signed [NUM_W-1:0] hoff;
    if (adv) begin
      hoff   = $signed(NUM_W'(h3_q)) * K60 + WH;
      beh4_q <= (z_q[0] <= 0) || (z_q[1] <= 0);
      for (int v = 0; v < 2; v++) begin
        z64 = NUM_W'(z_q[v]);
        num_q[3*v]     <= (z64 - NUM_W'(lat_q[v])) * CW;
        den_q[3*v]     <= DEN_W'(z64);
        num_q[3*v + 1] <= K60CH * z64 - (hoff <<< DEPTH_FRAC);
        den_q[3*v + 1] <= DEN_W'(z64 * K60);
        num_q[3*v + 2] <= K60CH * z64 + (WH <<< DEPTH_FRAC);
        den_q[3*v + 2] <= DEN_W'(z64 * K60);
      end
    end
  end

  // stage 5: sign split and quotient range check
  always_ff @(posedge clk_i) begin
    logic [NUM_W-1:0] mag;
    if (adv) begin
      beh5_q <= beh4_q;
      for (int l = 0; l < N_LANES; l++) begin
        mag = num_q[l][NUM_W-1] ? NUM_W'(-num_q[l]) : NUM_W'(num_q[l]);
        lanes5_q[l].neg <= num_q[l][NUM_W-1];
        lanes5_q[l].rem <= mag;
        lanes5_q[l].den <= den_q[l];
        lanes5_q[l].ovf <= mag >= {den_q[l], {QUO_W{1'b0}}};
        lanes5_q[l].quo <= '0;
      end
    end
  end

  // divider, behind flag travels alongside
  lanes_t div_lanes;
  logic   beh_pipe_q [DIV_STAGES];

  wepp_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (v5_q),
    .lanes_i     (lanes5_q),
    .out_valid_o (div_valid),
    .lanes_o     (div_lanes)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      beh_pipe_q[0] <= beh5_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        beh_pipe_q[k] <= beh_pipe_q[k-1];
      end
    end
  end

  // signed result with saturation
  function automatic logic signed [OUT_W-1:0] sat_lane(input div_lane_t ln);
    logic signed [OUT_W-1:0] r;
    if (ln.neg) begin
      r = (ln.ovf || ln.quo > 16'd32768) ? 16'sh8000 : OUT_W'(16'd0 - ln.quo);
    end else begin
      r = (ln.ovf || ln.quo[QUO_W-1]) ? 16'sh7fff : OUT_W'(ln.quo);
    end
    return r;
  endfunction

  // final stage
  logic signed [OUT_W-1:0] fin_q  [N_LANES];
  logic                    fin_beh_q;
  logic signed [OUT_W-1:0] hold_q [N_LANES];
  logic                    hold_beh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (adv) begin
      fin_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_beh_q <= beh_pipe_q[DIV_STAGES-1];
      for (int l = 0; l < N_LANES; l++) begin
        fin_q[l] <= beh_pipe_q[DIV_STAGES-1] ? '0 : sat_lane(div_lanes[l]);
      end
    end
  end

  // holding register and segment counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      seg_q        <= SEG_TOP;
    end else begin
      if (hold_load) begin
        hold_valid_q <= 1'b1;
        seg_q        <= SEG_TOP;
      end else if (out_fire) begin
        if (seg_q == SEG_RIGHT) begin
          hold_valid_q <= 1'b0;
        end
        seg_q <= seg_kind_e'(seg_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      hold_beh_q <= fin_beh_q;
      for (int l = 0; l < N_LANES; l++) begin
        hold_q[l] <= fin_q[l];
      end
    end
  end

  // segment select
  always_comb begin
    unique case (seg_q)
      SEG_TOP: begin
        start_x_o = hold_q[LANE_X1];
        start_y_o = hold_q[LANE_TOP1];
        end_x_o   = hold_q[LANE_X2];
        end_y_o   = hold_q[LANE_TOP2];
      end
      SEG_BOTTOM: begin
        start_x_o = hold_q[LANE_X1];
        start_y_o = hold_q[LANE_BOT1];
        end_x_o   = hold_q[LANE_X2];
        end_y_o   = hold_q[LANE_BOT2];
      end
      SEG_LEFT: begin
        start_x_o = hold_q[LANE_X1];
        start_y_o = hold_q[LANE_TOP1];
        end_x_o   = hold_q[LANE_X1];
        end_y_o   = hold_q[LANE_BOT1];
      end
      SEG_RIGHT: begin
        start_x_o = hold_q[LANE_X2];
        start_y_o = hold_q[LANE_TOP2];
        end_x_o   = hold_q[LANE_X2];
        end_y_o   = hold_q[LANE_BOT2];
      end
      default: begin
        start_x_o = '0;
        start_y_o = '0;
        end_x_o   = '0;
        end_y_o   = '0;
      end
    endcase
  end

  assign out_valid_o     = hold_valid_q;
  assign segment_kind_o  = seg_q;
  assign behind_camera_o = hold_beh_q;
  assign last_segment_o  = (seg_q == SEG_RIGHT);

endmodule

`default_nettype wire

// ===== sv/wepp_divider.sv =====
// ----------------------------------------------------------------------------
// wepp_divider
// Pipelined restoring divider, one quotient bit per stage, six lanes wide.
// ----------------------------------------------------------------------------
`default_nettype none

module wepp_divider
  import wepp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   in_valid_i,
  input  wire lanes_t lanes_i,
  output logic        out_valid_o,
  output lanes_t      lanes_o
);

  lanes_t                  st_q [DIV_STAGES];
  logic [DIV_STAGES-1:0]   vld_q;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    lanes_t src;
    lanes_t st_d;
    logic   src_vld;

    assign src     = (k == 0) ? lanes_i : st_q[(k == 0) ? 0 : k - 1];
    assign src_vld = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];

    // trial subtract of the shifted divisor
    always_comb begin
      logic [NUM_W-1:0] trial;
      st_d = src;
      for (int l = 0; l < N_LANES; l++) begin
        trial = NUM_W'(src[l].den) << B;
        if (src[l].rem >= trial) begin
          st_d[l].rem    = src[l].rem - trial;
          st_d[l].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign out_valid_o = vld_q[DIV_STAGES-1];
  assign lanes_o     = st_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== tb/tb_wall_edge_perspective_project.sv =====
// ----------------------------------------------------------------------------
// tb_wall_edge_perspective_project
// Self-checking bench for the wall edge projection block. Edges are sent with
// bursty timing and a randomly stalling segment sink; every edge is projected
// by a local fixed-point predictor and each segment transfer is compared field
// by field against the oldest predicted segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wall_edge_perspective_project
  import wepp_pkg::*;
;

  localparam int SCR_W = 800;
  localparam int SCR_H = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    seg_kind_e          kind;
    logic               behind;
    logic               last;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [23:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic [15:0] wall_height_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] start_x_o, start_y_o, end_x_o, end_y_o;
  logic [1:0] segment_kind_o;
  logic behind_camera_o, last_segment_o;

  wall_edge_perspective_project #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // camera copy used by the predictor
  logic signed [23:0] cam_x = '0, cam_y = '0;
  logic signed [15:0] cos_a = 16'sd16384, sin_a = '0;

  segment_t seg_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit stall_pattern_on = 1'b1;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (at %0t)", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // project one vertex into screen x, top y and bottom y
  function automatic bit project_vertex(input longint vx, input longint vy, input longint h,
                                        output longint sx, output longint top,
                                        output longint bot);
    longint dx, dy, depth, lat, cw, chh, wh, den;
    dx = vx - longint'(cam_x);
    dy = vy - longint'(cam_y);
    depth = dx * longint'(cos_a) + dy * longint'(sin_a);
    lat = dx * longint'(sin_a) - dy * longint'(cos_a);
    cw = SCR_W / 2;
    chh = SCR_H / 2;
    wh = longint'(SCR_W) * SCR_H;
    sx = 0; top = 0; bot = 0;
    if (depth <= 0) return 1'b0;
    sx = sat16((cw * depth - lat * cw) / depth);
    den = 60 * depth;
    top = sat16((chh * den + (-60 * h - wh) * (longint'(1) << 22)) / den);
    bot = sat16((chh * den + wh * (longint'(1) << 22)) / den);
    return 1'b1;
  endfunction

  // predict the four segments of one edge
  task automatic predict_edge(input logic signed [23:0] ax, ay, bx, by,
                              input logic [15:0] h);
    longint x1, t1, b1, x2, t2, b2;
    longint pts[4][4];
    bit ok1, ok2, behind;
    segment_t s;
    ok1 = project_vertex(ax, ay, h, x1, t1, b1);
    ok2 = project_vertex(bx, by, h, x2, t2, b2);
    behind = !(ok1 && ok2);
    pts[0] = '{x1, t1, x2, t2};
    pts[1] = '{x1, b1, x2, b2};
    pts[2] = '{x1, t1, x1, b1};
    pts[3] = '{x2, t2, x2, b2};
    for (int k = 0; k < 4; k++) begin
      s.sx = behind ? '0 : 16'(pts[k][0]);
      s.sy = behind ? '0 : 16'(pts[k][1]);
      s.ex = behind ? '0 : 16'(pts[k][2]);
      s.ey = behind ? '0 : 16'(pts[k][3]);
      s.kind = seg_kind_e'(k);
      s.behind = behind;
      s.last = (k == 3);
      seg_q.push_back(s);
    end
  endtask

  // send one edge; returns after the transfer
  task automatic send_edge(input logic signed [23:0] ax, ay, bx, by, input logic [15:0] h);
    first_x_i <= ax; first_y_i <= ay; second_x_i <= bx; second_y_i <= by;
    wall_height_i <= h;
    in_valid_i <= 1'b1;
    predict_edge(ax, ay, bx, by, h);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid with a random gap, or keep it up inside a burst
  int burst_left = 0;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    burst_left = $urandom_range(0, 8);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CAMERA_X:  cam_x = val[23:0];
      REG_CAMERA_Y:  cam_y = val[23:0];
      REG_COS_ANGLE: cos_a = val[15:0];
      REG_SIN_ANGLE: sin_a = val[15:0];
    endcase
  endtask

  task automatic set_camera(input logic [23:0] x, y, input logic [15:0] c, s);
    write_reg(REG_CAMERA_X, {{8{x[23]}}, x});
    write_reg(REG_CAMERA_Y, {{8{y[23]}}, y});
    write_reg(REG_COS_ANGLE, {{16{c[15]}}, c});
    write_reg(REG_SIN_ANGLE, {{16{s[15]}}, s});
  endtask

  // wait for all segments, then let the pipeline go idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] near24();
    return 24'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
  endfunction

  task automatic send_random(input int n, input bit wide);
    logic [23:0] v[4];
    for (int i = 0; i < n; i++) begin
      foreach (v[j]) v[j] = (wide || $urandom_range(0, 4) == 0) ? 24'($urandom) : near24();
      // mostly in front of a camera looking down +x
      if (!wide && $urandom_range(0, 3) != 0) begin
        v[0] = 24'($urandom_range(1, 1 << 14));
        v[2] = 24'($urandom_range(1, 1 << 14));
      end
      send_edge(v[0], v[1], v[2], v[3], 16'($urandom));
      pace();
    end
  endtask

  // directed: field extremes and the depth-not-positive case
  task automatic test_directed();
    send_edge(24'sd256, -24'sd128, 24'sd512, 24'sd128, 16'd0);
    send_edge(24'sd1, 24'sd0, 24'sd1, 24'sd1, 16'hFFFF);
    send_edge(24'sd0, 24'sd5, 24'sd256, 24'sd5, 16'd10);
    send_edge(-24'sd256, 24'sd0, 24'sd256, 24'sd0, 16'd10);
    send_edge(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'd1);
    send_edge(24'h800000, 24'h800000, 24'h7FFFFF, 24'h000000, 16'h8000);
    send_edge(24'h7FFFFF, 24'h800000, 24'h000100, 24'h7FFFFF, 16'h7FFF);
    send_edge(24'sd1, 24'h7FFFFF, 24'sd1, 24'h800000, 16'd1);
    send_edge(24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555);
    drain();
  endtask

  task automatic test_camera_extremes();
    set_camera(24'h7FFFFF, 24'h800000, 16'h8000, 16'h7FFF);
    send_edge(24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF, 16'hAAAA);
    send_edge(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 16'h0001);
    drain();
    set_camera(24'h800000, 24'h7FFFFF, 16'hC000, 16'h4000);
    send_edge(24'h7FFFFF, 24'h000000, 24'h7FFFFF, 24'h000100, 16'hFFFF);
    send_edge(24'h000000, 24'h800000, 24'h000100, 24'h800000, 16'h0);
    drain();
  endtask

  task automatic test_random_angles();
    logic [15:0] c, s;
    for (int phase = 0; phase < 5; phase++) begin
      c = (phase == 0) ? 16'sd16384 : 16'($urandom);
      s = (phase == 0) ? 16'sd0 : (phase == 1 ? 16'sd0 : 16'($urandom_range(0, 32767)));
      set_camera(phase < 2 ? 24'h0 : near24(), phase < 2 ? 24'h0 : near24(), c, s);
      send_random(22, phase == 4);
      drain();
    end
  endtask

  // receiver never stalls
  task automatic test_free_flow();
    stall_pattern_on = 1'b0;
    send_random(10, 1'b0);
    drain();
    stall_pattern_on = 1'b1;
  endtask

  // long receiver hold-off while edges keep coming
  task automatic test_backpressure();
    set_camera(24'h0, 24'h0, 16'sd16384, 16'sd0);
    hold_off = 150;
    burst_left = 30;
    send_random(25, 1'b0);
    drain();
  endtask

  // receiver stall pattern and hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pattern_on) begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // segment checker
  always @(posedge clk_i) begin
    segment_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (seg_q.size() == 0) begin
        report("unexpected segment kind", segment_kind_o, -1);
      end else begin
        w = seg_q.pop_front();
        if (start_x_o !== w.sx) report("start_x", start_x_o, w.sx);
        if (start_y_o !== w.sy) report("start_y", start_y_o, w.sy);
        if (end_x_o !== w.ex) report("end_x", end_x_o, w.ex);
        if (end_y_o !== w.ey) report("end_y", end_y_o, w.ey);
        if (segment_kind_o !== w.kind) report("segment_kind", segment_kind_o, w.kind);
        if (behind_camera_o !== w.behind) report("behind_camera", behind_camera_o, w.behind);
        if (last_segment_o !== w.last) report("last_segment", last_segment_o, w.last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_wall_edge_perspective_project: errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_camera_extremes();
    test_random_angles();
    test_free_flow();
    test_backpressure();
    if (errors == 0 && seg_q.size() == 0) begin
      $display("tb_wall_edge_perspective_project: clean");
    end else begin
      $display("tb_wall_edge_perspective_project: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
